// ===== hw/rtl/stlb_pkg.sv =====
// Package for the sorted-table lower-bound block: request kinds, field widths
// and the result record passed from the search controller to the top level.
// No dependencies.
package stlb_pkg;

	localparam int VAL_W = 32;
	localparam int POS_W = 11;
	localparam int KIND_W = 2;

	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             status;
	} res_t;

endpackage

// ===== hw/rtl/sorted_table_lower_bound_top.sv =====
// Top level of the sorted-table lower-bound block: entry store, request
// sequencer and the result register. Depends on stlb_pkg, stlb_mem, stlb_ctrl.
//
// Holds up to TABLE_DEPTH signed 32-bit entries loaded in ascending order.
// Each request gives one result. An append (kind 0) writes the next entry and
// returns the new count; on a full table it is dropped, the count is returned
// and status is 1. A clear (kind 2) empties the table and returns 0; stored
// words stay but are never read before being rewritten, so the store needs no
// clearing pass after reset. A query (kind 1) returns the smallest index whose
// entry is at least the target, or the count if none is. Kind 3 returns the
// count and changes nothing. Requests are taken one at a time: an append,
// clear or kind 3 goes straight from acceptance to the result state; a query
// makes P probes, where P depends on the path the search takes and is at
// most ceil(log2(count + 1)) (10 or 11 for a full table of 1024). Each probe
// reads the store's registered read port in S_READ, then does the compare and
// range update in S_CMP.
// The result register lets the next request be accepted while a result is
// still waiting on a stalled output; position is the low 11 bits.
module sorted_table_lower_bound_top #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [stlb_pkg::KIND_W-1:0]       kind,
	input  logic signed [stlb_pkg::VAL_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [stlb_pkg::POS_W-1:0]        position,
	output logic                              status
);
	import stlb_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic                    mem_wr_en;
	logic                    mem_rd_en;
	logic [AW-1:0]           mem_addr;
	logic signed [VAL_W-1:0] mem_wdata;
	logic signed [VAL_W-1:0] mem_rdata;

	logic                    res_valid;
	logic                    res_take;
	res_t                    res;

	logic                    out_valid_q;
	res_t                    out_q;

	stlb_mem #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW         (AW)
	) u_mem (
		.clk  (clk),
		.wr_en(mem_wr_en),
		.rd_en(mem_rd_en),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	stlb_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW         (AW),
		.CW         (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.value    (value),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res),
		.mem_wr_en(mem_wr_en),
		.mem_rd_en(mem_rd_en),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	// take a finished result whenever the output slot is empty or draining
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	// hold the payload while stalled; load only when a result moves in
	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign position  = out_q.position;
	assign status    = out_q.status;

endmodule

// ===== hw/rtl/stlb_mem.sv =====
// Entry store of the sorted table: one write port, one read port with
// registered read data. Depends on stlb_pkg.
module stlb_mem #(
	parameter int TABLE_DEPTH = 1024,
	parameter int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                            clk,
	input  logic                            wr_en,
	input  logic                            rd_en,
	input  logic [AW-1:0]                   addr,
	input  logic signed [stlb_pkg::VAL_W-1:0] wdata,
	output logic signed [stlb_pkg::VAL_W-1:0] rdata
);
	import stlb_pkg::*;

	logic signed [VAL_W-1:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== hw/rtl/stlb_ctrl.sv =====
// Request sequencer: appends, clears and the binary-search probe loop that
// drives the entry store. Depends on stlb_pkg.
module stlb_ctrl #(
	parameter int TABLE_DEPTH = 1024,
	parameter int AW = $clog2(TABLE_DEPTH),
	parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [stlb_pkg::KIND_W-1:0]       kind,
	input  logic signed [stlb_pkg::VAL_W-1:0] value,
	output logic                              res_valid,
	input  logic                              res_take,
	output stlb_pkg::res_t                    res,
	output logic                              mem_wr_en,
	output logic                              mem_rd_en,
	output logic [AW-1:0]                     mem_addr,
	output logic signed [stlb_pkg::VAL_W-1:0] mem_wdata,
	input  logic signed [stlb_pkg::VAL_W-1:0] mem_rdata
);
	import stlb_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_DONE
	} state_t;

	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           lo_q;
	logic [CW-1:0]           hx_q;
	logic signed [VAL_W-1:0] target_q;
	res_t                    res_q;

	logic                    accept;
	logic [CW-1:0]           probe;
	logic                    hit;
	logic [CW-1:0]           lo_nxt;
	logic [CW-1:0]           hx_nxt;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);

	// probe at the middle of [lo, hx), rounded down as in a closed-range search
	assign probe  = lo_q + ((hx_q - lo_q - CW'(1)) >> 1);
	assign hit    = (mem_rdata >= target_q);
	assign lo_nxt = hit ? lo_q : probe + CW'(1);
	assign hx_nxt = hit ? probe : hx_q;

	assign mem_wr_en = accept && (kind == KIND_APPEND) && (count_q < DEPTH_C);
	assign mem_rd_en = (state_q == S_READ);
	assign mem_addr  = mem_wr_en ? count_q[AW-1:0] : probe[AW-1:0];
	assign mem_wdata = value;

	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			lo_q     <= '0;
			hx_q     <= '0;
			target_q <= '0;
			res_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q.status <= 1'b0;
						case (kind)
							KIND_APPEND: begin
								if (count_q < DEPTH_C) begin
									count_q        <= count_q + CW'(1);
									res_q.position <= POS_W'(count_q + CW'(1));
								end else begin
									res_q.position <= POS_W'(count_q);
									res_q.status   <= 1'b1;
								end
								state_q <= S_DONE;
							end
							KIND_QUERY: begin
								target_q <= value;
								lo_q     <= '0;
								hx_q     <= count_q;
								if (count_q == '0) begin
									res_q.position <= '0;
									state_q        <= S_DONE;
								end else begin
									state_q <= S_READ;
								end
							end
							KIND_CLEAR: begin
								count_q        <= '0;
								res_q.position <= '0;
								state_q        <= S_DONE;
							end
							default: begin
								res_q.position <= POS_W'(count_q);
								state_q        <= S_DONE;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					lo_q <= lo_nxt;
					hx_q <= hx_nxt;
					if (lo_nxt < hx_nxt) begin
						state_q <= S_READ;
					end else begin
						// the last qualifying probe is where the upper bound settled
						res_q.position <= POS_W'(hx_nxt);
						state_q        <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above table depth");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_rd_en |-> (lo_q < hx_q) && (hx_q <= count_q))
		else $error("probe outside loaded entries");

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> $past(mem_rd_en))
		else $error("compare without a preceding read");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_q.status) |-> (count_q == DEPTH_C))
		else $error("append flagged dropped with room in table");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> (state_q == S_IDLE) && !mem_rd_en)
		else $error("store write overlaps a search");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for sorted_table_lower_bound_top: a directed table of
// requests followed by random load-and-search sequences under mixed idle/stall.
// Depends on stlb_pkg and the RTL of sorted_table_lower_bound_top.
module testbench;
	import stlb_pkg::*;

	localparam int DEPTH = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_REQUESTS = 130;
	// Kind 3 has no name in the package; the block must treat it as a no-op.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	// Idle and stall mixes per phase: none, sender only, receiver only, both.
	localparam int SEND_IDLE [0:3] = '{0, 45, 0, 25};
	localparam int RECV_STALL [0:3] = '{0, 0, 45, 25};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [KIND_W-1:0]       kind = KIND_APPEND;
	logic signed [VAL_W-1:0] value = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [POS_W-1:0]        position;
	logic                    status;

	// Mirror of the block's table, kept in step with accepted requests.
	logic signed [VAL_W-1:0] table_model [0:DEPTH-1];
	int table_len = 0;
	int peak_len = 0;
	int dropped_appends = 0;

	res_t pending_results [$];
	res_t head_result;

	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int cycle_count = 0;

	// Directed request table. Where fixed is set the expected result is given
	// in the row; otherwise the table mirror works it out.
	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic signed [VAL_W-1:0] value;
		logic                    fixed;
		logic [POS_W-1:0]        position;
		logic                    status;
	} step_row_t;

	step_row_t steps [0:24];

	sorted_table_lower_bound_top #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.position(position),
		.status(status)
	);

	always #10 clk = ~clk;

	// Binary search with the same probe sequence as the block: midpoint of the
	// closed range, rounding down, so unsorted contents give matching answers.
	function automatic logic [POS_W-1:0] lower_bound_of(input logic signed [VAL_W-1:0] target);
		int lo;
		int hi;
		int probe;
		logic [POS_W-1:0] found;
		lo = 0;
		hi = table_len - 1;
		found = table_len[POS_W-1:0];
		while (lo <= hi) begin
			probe = lo + (hi - lo) / 2;
			if (table_model[probe] >= target) begin
				found = probe[POS_W-1:0];
				hi = probe - 1;
			end else begin
				lo = probe + 1;
			end
		end
		return found;
	endfunction

	// Apply one accepted request to the mirror and return the result it gives.
	function automatic res_t table_step(input logic [KIND_W-1:0] k,
			input logic signed [VAL_W-1:0] v);
		res_t r;
		r.status = 1'b0;
		case (k)
		KIND_APPEND: begin
			if (table_len < DEPTH) begin
				table_model[table_len] = v;
				table_len++;
				if (table_len > peak_len)
					peak_len = table_len;
			end else begin
				// Full table: drop the entry and flag it.
				r.status = 1'b1;
				dropped_appends++;
			end
			r.position = table_len[POS_W-1:0];
		end
		KIND_QUERY: begin
			r.position = lower_bound_of(v);
		end
		KIND_CLEAR: begin
			table_len = 0;
			r.position = '0;
		end
		default: begin
			r.position = table_len[POS_W-1:0];
		end
		endcase
		return r;
	endfunction

	// Present one request from a falling edge, hold it until taken, then log
	// its expected result. Returns on the falling edge after acceptance.
	task automatic send_request(input logic [KIND_W-1:0] k, input logic signed [VAL_W-1:0] v,
			input logic fixed, input logic [POS_W-1:0] fixed_pos, input logic fixed_status);
		res_t predicted;
		// Random idle cycles ahead of the request.
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = table_step(k, v);
		if (fixed) begin
			predicted.position = fixed_pos;
			predicted.status = fixed_status;
		end
		pending_results.push_back(predicted);
		requests_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every outstanding result has come back.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// One well-formed sequence: clear (mostly), load ascending values, search.
	// A little noise is mixed in: unsorted appends, kind 3, stray clears.
	task automatic load_and_query(input int n_append, input int n_query, input bit keep_table);
		longint unsigned cur;
		longint unsigned step_max;
		logic signed [VAL_W-1:0] v;
		int i;
		int idx;
		if (!keep_table)
			send_request(KIND_CLEAR, $urandom, 1'b0, '0, 1'b0);
		// Spread the values over whatever room lies above a random start.
		cur = $urandom;
		step_max = (64'hFFFF_FFFF - cur) / (n_append + 1);
		if ($urandom_range(3) == 0 && step_max > 2)
			step_max = 2;
		for (i = 0; i < n_append; i++) begin
			cur = cur + $urandom_range(32'(step_max));
			v = cur[31:0] ^ 32'h8000_0000;
			if ($urandom_range(99) < 6)
				v = $urandom;
			if ($urandom_range(99) < 3)
				send_request(KIND_UNUSED, $urandom, 1'b0, '0, 1'b0);
			send_request(KIND_APPEND, v, 1'b0, '0, 1'b0);
		end
		for (i = 0; i < n_query; i++) begin
			v = $urandom;
			if (table_len > 0) begin
				idx = $urandom_range(table_len - 1);
				case ($urandom_range(5))
				0, 1: v = table_model[idx];
				2: v = table_model[idx] + 1;
				3: v = table_model[idx] - 1;
				4: v = $urandom_range(1) ? VAL_MIN : VAL_MAX;
				default: ;
				endcase
			end
			if ($urandom_range(99) < 2)
				send_request(KIND_CLEAR, $urandom, 1'b0, '0, 1'b0);
			else if ($urandom_range(99) < 3)
				send_request(KIND_UNUSED, v, 1'b0, '0, 1'b0);
			send_request(KIND_QUERY, v, 1'b0, '0, 1'b0);
		end
	endtask

	// Receiver stalls at random; changes on the falling edge like the inputs.
	always @(negedge clk)
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual position %0d status %0b",
					$time, position, status);
				errors++;
			end else begin
				head_result = pending_results.pop_front();
				results_checked++;
				if (position !== head_result.position) begin
					$display("%0t: position mismatch: expected %0d, actual %0d",
						$time, head_result.position, position);
					errors++;
				end
				if (status !== head_result.status) begin
					$display("%0t: status mismatch: expected %0b, actual %0b",
						$time, head_result.status, status);
					errors++;
				end
			end
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int phase;
		int phase_end;
		int pick;
		int n_append;
		int row;

		// Empty table, extremes, duplicates, kind 3, clear, then an unsorted pair.
		steps = '{
			'{KIND_QUERY,  32'sd0,  1'b1, 11'd0, 1'b0},
			'{KIND_UNUSED, 32'sd0,  1'b1, 11'd0, 1'b0},
			'{KIND_APPEND, VAL_MIN, 1'b1, 11'd1, 1'b0},
			'{KIND_APPEND, -32'sd5, 1'b1, 11'd2, 1'b0},
			'{KIND_APPEND, 32'sd0,  1'b1, 11'd3, 1'b0},
			'{KIND_APPEND, 32'sd7,  1'b1, 11'd4, 1'b0},
			'{KIND_APPEND, 32'sd7,  1'b1, 11'd5, 1'b0},
			'{KIND_APPEND, VAL_MAX, 1'b1, 11'd6, 1'b0},
			'{KIND_QUERY,  VAL_MIN, 1'b1, 11'd0, 1'b0},
			'{KIND_QUERY,  VAL_MAX, 1'b0, 11'd0, 1'b0},
			'{KIND_QUERY,  32'sd7,  1'b0, 11'd0, 1'b0},
			'{KIND_QUERY,  32'sd8,  1'b0, 11'd0, 1'b0},
			'{KIND_QUERY,  -32'sd6, 1'b0, 11'd0, 1'b0},
			'{KIND_QUERY,  32'sd1,  1'b0, 11'd0, 1'b0},
			'{KIND_UNUSED, -32'sd1, 1'b1, 11'd6, 1'b0},
			'{KIND_CLEAR,  32'sd0,  1'b1, 11'd0, 1'b0},
			'{KIND_QUERY,  32'sd0,  1'b1, 11'd0, 1'b0},
			'{KIND_APPEND, VAL_MAX, 1'b1, 11'd1, 1'b0},
			'{KIND_APPEND, VAL_MIN, 1'b1, 11'd2, 1'b0},
			'{KIND_QUERY,  32'sd0,  1'b0, 11'd0, 1'b0},
			'{KIND_QUERY,  -32'sd1, 1'b0, 11'd0, 1'b0},
			'{KIND_CLEAR,  -32'sd1, 1'b1, 11'd0, 1'b0},
			'{KIND_UNUSED, VAL_MIN, 1'b1, 11'd0, 1'b0},
			'{KIND_APPEND, -32'sd1, 1'b1, 11'd1, 1'b0},
			'{KIND_QUERY,  VAL_MAX, 1'b0, 11'd0, 1'b0}
		};

		// Hold reset, then release it on a falling edge.
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (row = 0; row < 25; row++)
			send_request(steps[row].kind, steps[row].value, steps[row].fixed,
				steps[row].position, steps[row].status);
		hold_until_drained();

		for (phase = 0; phase < 4; phase++) begin
			idle_pct = SEND_IDLE[phase];
			stall_pct = RECV_STALL[phase];
			// Fill the table to the brim once, then push a few appends past it.
			if (phase == 3)
				load_and_query(DEPTH + 3, 40, 1'b0);
			phase_end = requests_sent + PHASE_REQUESTS;
			while (requests_sent < phase_end) begin
				// Mostly short tables, now and then a longer one.
				pick = $urandom_range(99);
				if (pick < 70)
					n_append = $urandom_range(24);
				else if (pick < 95)
					n_append = $urandom_range(120, 25);
				else
					n_append = $urandom_range(300, 121);
				load_and_query(n_append, $urandom_range(16, 1), $urandom_range(7) == 0);
			end
			// Pause the sender until the block has answered everything.
			hold_until_drained();
		end

		stall_pct = 0;
		repeat (40) @(posedge clk);

		$display("Sent %0d requests over four idle/stall mixes and checked %0d results;",
			requests_sent, results_checked);
		$display("table peaked at %0d entries, %0d appends dropped on a full table.",
			peak_len, dropped_appends);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
